@@ rtl/core/bcpg_pkg.sv @@
// ----------------------------------------------------------------------------
// bcpg_pkg
// Shared types and constants of the B-spline curve point generator.
// ----------------------------------------------------------------------------
`default_nettype none

package bcpg_pkg;

  // field widths
  localparam int NP_W   = 7;
  localparam int ORD_W  = 4;
  localparam int STEP_W = 24;
  localparam int IDX_W  = 6;
  localparam int CRD_W  = 32;
  localparam int PAR_W  = 23;
  localparam int CNT_W  = 32;
  localparam int BAS_W  = 31;

  // parameter defaults
  localparam int DEF_MAX_POINTS = 64;
  localparam int DEF_MAX_ORDER  = 8;

  // command queue depth
  localparam int QDEPTH = 2;

  // configuration register indexes
  localparam int CFG_AW = 2;
  localparam logic [CFG_AW-1:0] CFG_NUM_POINTS = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_ORDER      = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_STEP_SIZE  = 2'd2;

  // configuration reset values
  localparam logic [NP_W-1:0]   RST_NUM_POINTS = 7'd4;
  localparam logic [ORD_W-1:0]  RST_ORDER      = 4'd4;
  localparam logic [STEP_W-1:0] RST_STEP_SIZE  = 24'd65536;

  // saturation limits
  localparam logic [PAR_W-1:0] PAR_MAX = {PAR_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // one in Q1.30
  localparam logic [BAS_W-1:0] BASIS_ONE = 31'h4000_0000;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } op_e;

  typedef struct packed {
    logic [NP_W-1:0]   num_points;
    logic [ORD_W-1:0]  order;
    logic [STEP_W-1:0] step_size;
  } cfg_t;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] idx;
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic [PAR_W-1:0] u;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] cnt_nxt;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/bcpg_front.sv @@
// ----------------------------------------------------------------------------
// bcpg_front
// Accepts input items, tracks curve parameter and sample count, and issues
// load or emit commands into the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpg_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [bcpg_pkg::STEP_W-1:0]      step_size_i,
  input  logic                             push,
  output logic                             full,
  input  logic                             func_i,
  input  logic [bcpg_pkg::IDX_W-1:0]       point_index_i,
  input  logic signed [bcpg_pkg::CRD_W-1:0] point_x_i,
  input  logic signed [bcpg_pkg::CRD_W-1:0] point_y_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output bcpg_pkg::cmd_t                   q_data_o
);
  import bcpg_pkg::*;

  logic [PAR_W-1:0] u_q, u_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] cnt_inc;
  logic [PAR_W+1:0] u_sum;
  logic             accept;

  assign accept   = push & ~q_full_i;
  assign full     = q_full_i;
  assign q_push_o = accept;

  // saturating advance of parameter and count
  assign u_sum   = (PAR_W+2)'(u_q) + (PAR_W+2)'(step_size_i);
  assign cnt_inc = (cnt_q == CNT_MAX) ? CNT_MAX : cnt_q + CNT_W'(1);

  always_comb begin
    u_d   = u_q;
    cnt_d = cnt_q;
    if (accept) begin
      if (op_e'(func_i) == OP_LOAD) begin
        u_d   = '0;
        cnt_d = '0;
      end else begin
        u_d   = (u_sum > (PAR_W+2)'(PAR_MAX)) ? PAR_MAX : u_sum[PAR_W-1:0];
        cnt_d = cnt_inc;
      end
    end
  end

  // command built from the item and current state
  always_comb begin
    q_data_o.op      = op_e'(func_i);
    q_data_o.idx     = point_index_i;
    q_data_o.x       = point_x_i;
    q_data_o.y       = point_y_i;
    q_data_o.u       = u_q;
    q_data_o.cnt     = cnt_q;
    q_data_o.cnt_nxt = cnt_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q   <= '0;
      cnt_q <= '0;
    end else begin
      u_q   <= u_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bcpg_queue.sv @@
// ----------------------------------------------------------------------------
// bcpg_queue
// Short command queue between the front end and the evaluation engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpg_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bcpg_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output bcpg_pkg::cmd_t data_o,
  output logic           empty_o
);
  import bcpg_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  cmd_t          mem_q [QDEPTH];
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // pointer and fill update
  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_push) wp_d = (wp_q == PW'(QDEPTH - 1)) ? '0 : wp_q + PW'(1);
    if (do_pop)  rp_d = (rp_q == PW'(QDEPTH - 1)) ? '0 : rp_q + PW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end

endmodule

`default_nettype wire

@@ rtl/core/bcpg_engine.sv @@
// ----------------------------------------------------------------------------
// bcpg_engine
// Holds the control points and evaluates the Cox-de Boor triangle over the
// active knot span with one shared multiplier and a radix-256 divider.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpg_engine #(
  parameter int MAX_POINTS = bcpg_pkg::DEF_MAX_POINTS,
  parameter int MAX_ORDER  = bcpg_pkg::DEF_MAX_ORDER
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bcpg_pkg::cfg_t                    cfg_i,
  input  bcpg_pkg::cmd_t                    cmd_i,
  input  logic                              cmd_empty_i,
  output logic                              cmd_pop_o,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [bcpg_pkg::CRD_W-1:0] curve_x_o,
  output logic signed [bcpg_pkg::CRD_W-1:0] curve_y_o,
  output logic [bcpg_pkg::CNT_W-1:0]        sample_number_o,
  output logic                              done_res_o
);
  import bcpg_pkg::*;

  localparam int NW   = $clog2(MAX_POINTS + 1);
  localparam int TW   = $clog2(MAX_ORDER + 1);
  localparam int BD   = MAX_ORDER + 1;
  localparam int AW   = $clog2(MAX_POINTS);
  localparam int KW   = $clog2(MAX_POINTS + MAX_ORDER + 1);
  localparam int EW   = ((KW > 7) ? KW : 7) + 1;
  localparam int DW   = (NW + 16 > PAR_W) ? NW + 16 : PAR_W;
  localparam int PW   = DW + BAS_W;
  localparam int QW   = PW - 16;
  localparam int DVN  = (QW + 7) / 8;
  localparam int DIVW = DVN * 8;
  localparam int DCW  = $clog2(DVN + 1);
  localparam int LW   = NW + 16;
  localparam int LCW  = $clog2(LW + 1);
  localparam int SW   = 64;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_PREP    = 4'd1;
  localparam logic [3:0] ST_MUL     = 4'd2;
  localparam logic [3:0] ST_DIV     = 4'd3;
  localparam logic [3:0] ST_ACC_RD  = 4'd4;
  localparam logic [3:0] ST_ACC_MUL = 4'd5;
  localparam logic [3:0] ST_ACC_ADD = 4'd6;
  localparam logic [3:0] ST_FIN     = 4'd7;
  localparam logic [3:0] ST_LEN     = 4'd8;
  localparam logic [3:0] ST_OUT     = 4'd9;

  // clamped knot value at index i
  function automatic logic [NW-1:0] knot(input logic [KW-1:0] i,
                                         input logic [NW-1:0] n,
                                         input logic [TW-1:0] t);
    logic [KW-1:0] nk, tk;
    nk = KW'(n);
    tk = KW'(t);
    if (i < tk)      knot = '0;
    else if (i < nk) knot = NW'(i - tk + KW'(1));
    else             knot = NW'(nk - tk + KW'(1));
  endfunction

  // Q.46 sum to Q16.16 with truncation toward zero and saturation
  function automatic logic [CRD_W-1:0] to_coord(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] b, sh;
    b  = (s < 0) ? s + SW'(64'h3FFF_FFFF) : s;
    sh = b >>> 30;
    if (sh > SW'(64'sh7FFF_FFFF))        to_coord = 32'h7FFF_FFFF;
    else if (sh < -SW'(64'sh8000_0000))  to_coord = 32'h8000_0000;
    else                                 to_coord = sh[CRD_W-1:0];
  endfunction

  logic [3:0]          st_q;
  logic [NW-1:0]       n_eff;
  logic [TW-1:0]       t_eff;
  logic                curve_ok;
  logic                span_ok;
  logic [6:0]          seg;

  logic [PAR_W-1:0]    u_q;
  logic [CNT_W-1:0]    cnt_q, cnt_nxt_q;
  logic                curve_ok_q;
  logic [KW-1:0]       seg_q;
  logic [TW-1:0]       m_q, s_q;
  logic                half_q;

  logic [KW-1:0]       k_c;
  logic [NW-1:0]       uk, uks1, uk1, uks;
  logic [DW:0]         u_ext, uk16, uks16;
  logic [DW-1:0]       dist1_c, dist2_c;
  logic [DW-1:0]       dist1_q, dist2_q;
  logic [NW-1:0]       d1_q, d2_q;

  logic [BAS_W-1:0]    bmem [BD];
  logic [BD-1:0]       bvld_q;
  logic [BAS_W-1:0]    rd0_q, rd1_q;
  logic                bwe;
  logic [TW-1:0]       bwa;
  logic [BAS_W-1:0]    bwd;

  logic [CRD_W-1:0]    mem_x [MAX_POINTS];
  logic [CRD_W-1:0]    mem_y [MAX_POINTS];
  logic [CRD_W-1:0]    px_q, py_q;
  logic                ld_we;

  logic [DW-1:0]       mul_a;
  logic [BAS_W-1:0]    mul_b;
  logic [NW-1:0]       dsel;
  logic [PW-1:0]       prod_c;

  logic [DIVW-1:0]     dv_q, dv_n;
  logic [NW-1:0]       rm_q, rm_n, dd_q;
  logic [NW:0]         rx;
  logic [DCW-1:0]      dcnt_q;
  logic [BAS_W-1:0]    acc_q;

  logic signed [SW-1:0] mx_q, my_q, sx_q, sy_q;

  logic [LW-1:0]       ln_dv_q;
  logic [STEP_W-1:0]   ln_r_q;
  logic [STEP_W:0]     ln_rx;
  logic [LCW-1:0]      lcnt_q;
  logic [NW-1:0]       nt1;

  logic [CRD_W-1:0]    cx_q, cy_q;
  logic                res_vld_q;
  logic [CRD_W-1:0]    res_x_q, res_y_q;
  logic [CNT_W-1:0]    res_n_q;
  logic                res_done_q;
  logic                out_fire;

  // effective configuration
  always_comb begin
    if (int'(cfg_i.num_points) > MAX_POINTS) n_eff = NW'(MAX_POINTS);
    else                                      n_eff = NW'(cfg_i.num_points);
    if (cfg_i.order == '0)                   t_eff = TW'(1);
    else if (int'(cfg_i.order) > MAX_ORDER)  t_eff = TW'(MAX_ORDER);
    else                                     t_eff = TW'(cfg_i.order);
  end

  assign curve_ok = (KW'(t_eff) <= KW'(n_eff));
  assign seg      = cmd_i.u[PAR_W-1:16];
  assign span_ok  = (EW'(seg) + EW'(t_eff) <= EW'(n_eff));
  assign nt1      = NW'(KW'(n_eff) - KW'(t_eff) + KW'(1));

  assign cmd_pop_o = (st_q == ST_IDLE) && !cmd_empty_i;
  assign ld_we     = cmd_pop_o && (cmd_i.op == OP_LOAD) &&
                     (int'(cmd_i.idx) < MAX_POINTS);

  // knots and distances of the current term
  always_comb begin
    k_c     = KW'(seg_q) + KW'(m_q);
    uk      = knot(k_c, n_eff, t_eff);
    uks1    = knot(k_c + KW'(s_q) - KW'(1), n_eff, t_eff);
    uk1     = knot(k_c + KW'(1), n_eff, t_eff);
    uks     = knot(k_c + KW'(s_q), n_eff, t_eff);
    u_ext   = (DW+1)'(u_q);
    uk16    = (DW+1)'({uk, 16'h0000});
    uks16   = (DW+1)'({uks, 16'h0000});
    dist1_c = (u_ext >= uk16) ? DW'(u_ext - uk16) : '0;
    dist2_c = (uks16 > u_ext) ? DW'(uks16 - u_ext) : '0;
  end

  // shared multiplier operands
  assign mul_a  = half_q ? dist2_q : dist1_q;
  assign mul_b  = half_q ? rd1_q : rd0_q;
  assign dsel   = half_q ? d2_q : d1_q;
  assign prod_c = mul_a * mul_b;

  // eight restoring steps per cycle
  always_comb begin
    dv_n = dv_q;
    rm_n = rm_q;
    rx   = '0;
    for (int i = 0; i < 8; i++) begin
      rx   = {rm_n, dv_n[DIVW-1]};
      dv_n = {dv_n[DIVW-2:0], 1'b0};
      if (rx >= {1'b0, dd_q}) begin
        rx      = rx - {1'b0, dd_q};
        dv_n[0] = 1'b1;
      end
      rm_n = rx[NW-1:0];
    end
  end

  // one step of the curve length divider
  assign ln_rx = {ln_r_q, ln_dv_q[LW-1]};

  // basis write port
  always_comb begin
    bwe = 1'b0;
    bwa = m_q;
    bwd = acc_q + dv_n[BAS_W-1:0];
    if (cmd_pop_o && cmd_i.op == OP_EMIT) begin
      bwe = 1'b1;
      bwa = t_eff - TW'(1);
      bwd = BASIS_ONE;
    end else if (st_q == ST_DIV && dcnt_q == DCW'(DVN - 1) && half_q) begin
      bwe = 1'b1;
    end
  end

  assign out_fire = (st_q == ST_OUT) && (!res_vld_q || pop);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      bvld_q     <= '0;
      half_q     <= 1'b0;
      m_q        <= '0;
      s_q        <= '0;
      dcnt_q     <= '0;
      lcnt_q     <= '0;
      res_vld_q  <= 1'b0;
      curve_ok_q <= 1'b0;
    end else begin
      if (out_fire)                res_vld_q <= 1'b1;
      else if (pop && res_vld_q)   res_vld_q <= 1'b0;
      if (bwe) begin
        if (st_q == ST_IDLE) bvld_q <= BD'(1) << bwa;
        else                 bvld_q[bwa] <= 1'b1;
      end
      unique case (st_q)
        ST_IDLE: begin
          if (cmd_pop_o && cmd_i.op == OP_EMIT) begin
            curve_ok_q <= curve_ok;
            half_q     <= 1'b0;
            if (!curve_ok || !span_ok) begin
              st_q <= ST_FIN;
            end else if (t_eff == TW'(1)) begin
              m_q  <= '0;
              st_q <= ST_ACC_RD;
            end else begin
              s_q  <= TW'(2);
              m_q  <= t_eff - TW'(2);
              st_q <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          half_q <= 1'b0;
          st_q   <= ST_MUL;
        end
        ST_MUL: begin
          dcnt_q <= '0;
          st_q   <= ST_DIV;
        end
        ST_DIV: begin
          dcnt_q <= dcnt_q + DCW'(1);
          if (dcnt_q == DCW'(DVN - 1)) begin
            if (!half_q) begin
              half_q <= 1'b1;
              st_q   <= ST_MUL;
            end else if (m_q == t_eff - TW'(1)) begin
              if (s_q == t_eff) begin
                m_q  <= '0;
                st_q <= ST_ACC_RD;
              end else begin
                s_q  <= s_q + TW'(1);
                m_q  <= t_eff - s_q - TW'(1);
                st_q <= ST_PREP;
              end
            end else begin
              m_q  <= m_q + TW'(1);
              st_q <= ST_PREP;
            end
          end
        end
        ST_ACC_RD:  st_q <= ST_ACC_MUL;
        ST_ACC_MUL: st_q <= ST_ACC_ADD;
        ST_ACC_ADD: begin
          if (m_q == t_eff - TW'(1)) begin
            st_q <= ST_FIN;
          end else begin
            m_q  <= m_q + TW'(1);
            st_q <= ST_ACC_RD;
          end
        end
        ST_FIN: begin
          lcnt_q <= '0;
          if (curve_ok_q && cfg_i.step_size != '0) st_q <= ST_LEN;
          else                                      st_q <= ST_OUT;
        end
        ST_LEN: begin
          lcnt_q <= lcnt_q + LCW'(1);
          if (lcnt_q == LCW'(LW - 1)) st_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_fire) st_q <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: begin
        u_q       <= cmd_i.u;
        cnt_q     <= cmd_i.cnt;
        cnt_nxt_q <= cmd_i.cnt_nxt;
        seg_q     <= KW'(seg);
        sx_q      <= '0;
        sy_q      <= '0;
        ln_dv_q   <= '0;
      end
      ST_PREP: begin
        dist1_q <= dist1_c;
        dist2_q <= dist2_c;
        d1_q    <= uks1 - uk;
        d2_q    <= uks - uk1;
      end
      ST_MUL: begin
        rm_q <= '0;
        if (dsel == '0) begin
          dv_q <= '0;
          dd_q <= NW'(1);
        end else begin
          dv_q <= DIVW'(prod_c[PW-1:16]);
          dd_q <= dsel;
        end
      end
      ST_DIV: begin
        dv_q <= dv_n;
        rm_q <= rm_n;
        if (dcnt_q == DCW'(DVN - 1) && !half_q) acc_q <= dv_n[BAS_W-1:0];
      end
      ST_ACC_MUL: begin
        mx_q <= $signed(px_q) * $signed({1'b0, rd0_q});
        my_q <= $signed(py_q) * $signed({1'b0, rd0_q});
      end
      ST_ACC_ADD: begin
        sx_q <= sx_q + mx_q;
        sy_q <= sy_q + my_q;
      end
      ST_FIN: begin
        cx_q   <= to_coord(sx_q);
        cy_q   <= to_coord(sy_q);
        ln_r_q <= '0;
        // no curve or no step: length stays zero
        if (curve_ok_q && cfg_i.step_size != '0) ln_dv_q <= LW'({nt1, 16'h0000});
        else                                      ln_dv_q <= '0;
      end
      ST_LEN: begin
        if (ln_rx >= {1'b0, cfg_i.step_size}) begin
          ln_r_q  <= STEP_W'(ln_rx - {1'b0, cfg_i.step_size});
          ln_dv_q <= {ln_dv_q[LW-2:0], 1'b1};
        end else begin
          ln_r_q  <= ln_rx[STEP_W-1:0];
          ln_dv_q <= {ln_dv_q[LW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // basis scratch memory
  always_ff @(posedge clk_i) begin
    if (bwe) bmem[bwa] <= bwd;
    if (st_q == ST_PREP) begin
      rd0_q <= bvld_q[m_q] ? bmem[m_q] : '0;
      rd1_q <= bvld_q[m_q + TW'(1)] ? bmem[m_q + TW'(1)] : '0;
    end else if (st_q == ST_ACC_RD) begin
      rd0_q <= bvld_q[m_q] ? bmem[m_q] : '0;
    end
  end

  // control point memories
  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      mem_x[AW'(cmd_i.idx)] <= cmd_i.x;
      mem_y[AW'(cmd_i.idx)] <= cmd_i.y;
    end
    if (st_q == ST_ACC_RD) begin
      px_q <= mem_x[AW'(k_c)];
      py_q <= mem_y[AW'(k_c)];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      res_x_q    <= cx_q;
      res_y_q    <= cy_q;
      res_n_q    <= cnt_q;
      res_done_q <= (cfg_i.step_size != '0) && (cnt_nxt_q >= CNT_W'(ln_dv_q));
    end
  end

  assign empty           = !res_vld_q;
  assign curve_x_o       = res_x_q;
  assign curve_y_o       = res_y_q;
  assign sample_number_o = res_n_q;
  assign done_res_o      = res_done_q;

endmodule

`default_nettype wire

@@ rtl/core/bspline_curve_point_generator.sv @@
// ----------------------------------------------------------------------------
// bspline_curve_point_generator
// Clamped uniform B-spline evaluator: loads 2-D control points and emits one
// curve point per emit request.
// ----------------------------------------------------------------------------
//  channel   handshake         payload
//  input     push / full       func_i, point_index_i, point_x_i, point_y_i
//  result    empty / pop       curve_x_o, curve_y_o, sample_number_o, done_res_o
//  config    cfg_we_i          cfg_addr_i, cfg_wdata_i
//
//  A load is written to the point store as the engine pops it and gives no
//  result. An emit builds the basis triangle with the shared multiplier and
//  the 8-bit-per-cycle divider, then sums the weighted control points and
//  divides the curve length by the step for done_res_o.
//  A two-entry command queue lets the front end take items while the engine
//  works; a held result only stalls the engine at its final step.
//  Reset clears control state; the point store holds nothing until written.
// ----------------------------------------------------------------------------
`default_nettype none

module bspline_curve_point_generator #(
  parameter int MAX_POINTS = bcpg_pkg::DEF_MAX_POINTS,
  parameter int MAX_ORDER  = bcpg_pkg::DEF_MAX_ORDER
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bcpg_pkg::CFG_AW-1:0]       cfg_addr_i,
  input  logic [bcpg_pkg::STEP_W-1:0]       cfg_wdata_i,
  input  logic                              push,
  output logic                              full,
  input  logic                              func_i,
  input  logic [bcpg_pkg::IDX_W-1:0]        point_index_i,
  input  logic signed [bcpg_pkg::CRD_W-1:0] point_x_i,
  input  logic signed [bcpg_pkg::CRD_W-1:0] point_y_i,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [bcpg_pkg::CRD_W-1:0] curve_x_o,
  output logic signed [bcpg_pkg::CRD_W-1:0] curve_y_o,
  output logic [bcpg_pkg::CNT_W-1:0]        sample_number_o,
  output logic                              done_res_o
);
  import bcpg_pkg::*;

  cfg_t cfg_q;
  cmd_t f_cmd, b_cmd;
  logic f_push, q_full, q_empty, b_pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_points <= RST_NUM_POINTS;
      cfg_q.order      <= RST_ORDER;
      cfg_q.step_size  <= RST_STEP_SIZE;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_NUM_POINTS: cfg_q.num_points <= cfg_wdata_i[NP_W-1:0];
        CFG_ORDER:      cfg_q.order      <= cfg_wdata_i[ORD_W-1:0];
        CFG_STEP_SIZE:  cfg_q.step_size  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  bcpg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_size_i   (cfg_q.step_size),
    .push          (push),
    .full          (full),
    .func_i        (func_i),
    .point_index_i (point_index_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .q_full_i      (q_full),
    .q_push_o      (f_push),
    .q_data_o      (f_cmd)
  );

  bcpg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (f_cmd),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .data_o  (b_cmd),
    .empty_o (q_empty)
  );

  bcpg_engine #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_ORDER  (MAX_ORDER)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_i           (b_cmd),
    .cmd_empty_i     (q_empty),
    .cmd_pop_o       (b_pop),
    .empty           (empty),
    .pop             (pop),
    .curve_x_o       (curve_x_o),
    .curve_y_o       (curve_y_o),
    .sample_number_o (sample_number_o),
    .done_res_o      (done_res_o)
  );

endmodule

`default_nettype wire
